### src/lsi_pkg.sv
`timescale 1ns / 1ps
// Package for the sorted-insert stack: request and result types, codes and defaults.
package lsi_pkg;

	localparam int DEFAULT_DEPTH      = 16;
	localparam int DEFAULT_ITEM_WIDTH = 8;

	localparam int VALUE_W  = 8;
	localparam int COUNT_W  = 5;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_INSERT = 2'd1,
		OP_POP    = 2'd2,
		OP_QUERY  = 2'd3
	} op_e_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_e_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [VALUE_W-1:0] front_value;
		logic [COUNT_W-1:0] entry_count;
		logic               is_empty;
		logic [1:0]         status;
	} rsp_t;

	// Per-cycle command broadcast to every cell of the chain.
	typedef struct packed {
		logic push;
		logic insert;
		logic pop;
	} cell_ctl_t;

endpackage

### src/list_stack_sorted_insert_top.sv
`timescale 1ns / 1ps
// Top level of the bounded list used as a stack with sorted insert.
// The list lives in a row of DEPTH cells, cell 0 being the front. Every request
// (push front, insert sorted, pop front, query) is applied in the single cycle
// in which it is accepted, so one item per clock is taken unless req_stall is
// high; the clock period is set by the insert-position search, which ripples
// through the cell row. The result item, showing the list after the operation,
// is held in an output register backed by a skid stage, so requests keep
// flowing while one result waits. There is no clearing pass after reset.
module list_stack_sorted_insert_top import lsi_pkg::*; #(
	parameter int DEPTH      = DEFAULT_DEPTH,
	parameter int ITEM_WIDTH = DEFAULT_ITEM_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_d;
	logic                  accept;
	logic                  full;
	logic                  empty;
	logic [ITEM_WIDTH-1:0] value;
	cell_ctl_t             ctl;
	status_e_t             status;
	rsp_t                  result;

	logic [ITEM_WIDTH-1:0] entry     [DEPTH];
	logic [ITEM_WIDTH-1:0] entry_nxt [DEPTH];
	logic [DEPTH:0]        found;

	assign accept = req_valid && !req_stall;
	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign value  = ITEM_WIDTH'(req.value);

	always_comb begin
		ctl     = '0;
		count_d = count_q;
		status  = ST_OK;
		case (req.operation)
			OP_PUSH, OP_INSERT: begin
				if (full) begin
					status = ST_OVERFLOW;
				end else begin
					ctl.push   = accept && (req.operation == OP_PUSH);
					ctl.insert = accept && (req.operation == OP_INSERT);
					count_d    = count_q + CNT_W'(1);
				end
			end
			OP_POP: begin
				if (empty) begin
					status = ST_UNDERFLOW;
				end else begin
					ctl.pop = accept;
					count_d = count_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign found[0] = 1'b0;

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic [ITEM_WIDTH-1:0] left;
			logic [ITEM_WIDTH-1:0] right;

			if (i == 0) begin : g_front
				assign left = value;
			end else begin : g_mid
				assign left = entry[i-1];
			end

			if (i == DEPTH - 1) begin : g_back
				assign right = entry[i];
			end else begin : g_inner
				assign right = entry[i+1];
			end

			lsi_cell #(
				.ITEM_WIDTH(ITEM_WIDTH)
			) u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.occupied (CNT_W'(i) < count_q),
				.value    (value),
				.left     (left),
				.right    (right),
				.found_in (found[i]),
				.found_out(found[i+1]),
				.entry    (entry[i]),
				.entry_nxt(entry_nxt[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	always_comb begin
		result.front_value = (count_d != '0) ? VALUE_W'(entry_nxt[0]) : '0;
		result.entry_count = COUNT_W'(count_d);
		result.is_empty    = (count_d == '0);
		result.status      = status;
	end

	lsi_rsp_buf u_rsp_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_valid(req_valid),
		.load      (result),
		.load_stall(req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds the list depth");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.operation == OP_POP) && empty |=> (count_q == '0))
		else $error("pop of an empty list changed the count");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !full && ((req.operation == OP_PUSH) || (req.operation == OP_INSERT))
		|=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("accepted push did not grow the list by one");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && full && ((req.operation == OP_PUSH) || (req.operation == OP_INSERT))
		|=> $stable(count_q))
		else $error("insert into a full list changed the count");
`endif

endmodule

### src/lsi_cell.sv
`timescale 1ns / 1ps
// One storage cell of the list chain, with its share of the insert-position search.
module lsi_cell import lsi_pkg::*; #(
	parameter int ITEM_WIDTH = DEFAULT_ITEM_WIDTH
) (
	input  logic                  clk,
	input  cell_ctl_t             ctl,
	input  logic                  occupied,
	input  logic [ITEM_WIDTH-1:0] value,
	input  logic [ITEM_WIDTH-1:0] left,
	input  logic [ITEM_WIDTH-1:0] right,
	input  logic                  found_in,
	output logic                  found_out,
	output logic [ITEM_WIDTH-1:0] entry,
	output logic [ITEM_WIDTH-1:0] entry_nxt
);

	logic [ITEM_WIDTH-1:0] entry_q;
	logic                  gt;

	// An empty cell counts as greater, so the first free slot ends the search.
	assign gt        = !occupied || (entry_q > value);
	assign found_out = found_in | gt;

	always_comb begin
		entry_nxt = entry_q;
		if (ctl.push) begin
			entry_nxt = left;
		end else if (ctl.insert) begin
			if (found_in) begin
				entry_nxt = left;
			end else if (gt) begin
				entry_nxt = value;
			end
		end else if (ctl.pop) begin
			entry_nxt = right;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_nxt;
	end

	assign entry = entry_q;

endmodule

### src/lsi_rsp_buf.sv
`timescale 1ns / 1ps
// Output register with a skid stage for the result channel.
module lsi_rsp_buf import lsi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic load_valid,
	input  rsp_t load,
	output logic load_stall,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic out_valid_q;
	logic skid_valid_q;
	rsp_t out_q;
	rsp_t skid_q;
	logic load_take;
	logic out_free;

	assign load_stall = skid_valid_q;
	assign load_take  = load_valid && !skid_valid_q;
	assign out_free   = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q  <= skid_valid_q | load_take;
				skid_valid_q <= 1'b0;
			end else if (load_take) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : load;
		end else if (load_take) begin
			skid_q <= load;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
